// ===== design/csc_pkg.sv =====
`timescale 1ns / 1ps

package csc_pkg;

	// field widths fixed by the stream format
	localparam int POS_W    = 24;
	localparam int DIV_REM_W = 52;
	localparam int DIV_LOW_W = 17;
	localparam int DIV_DEN_W = 50;
	localparam int RES_W    = 26;

	// transaction kinds on the input stream
	localparam logic [0:0] KIND_LOAD  = 1'b0;
	localparam logic [0:0] KIND_QUERY = 1'b1;

	// iterative unit step counts and square root start bit
	localparam logic [4:0] T_STEPS    = 5'd16;
	localparam logic [4:0] NORM_STEPS = 5'd17;
	localparam logic [4:0] SQRT_STEPS = 5'd25;
	localparam int         SQRT_TOP   = 48;

	// command to the shared divide / square root unit
	typedef struct packed {
		logic                   start;
		logic                   sqrt;
		logic [4:0]             steps;
		logic [DIV_REM_W-1:0]   rem0;
		logic [DIV_LOW_W-1:0]   low;
		logic [DIV_DEN_W-1:0]   den;
	} div_cmd_t;

	// status back from the divide / square root unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [RES_W-1:0] res;
	} div_sts_t;

	// rounded right shift, ties away from zero
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
			input int unsigned s);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'd1 << (s - 1))) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	// clamp to the signed 24 bit field range
	function automatic logic signed [POS_W-1:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[POS_W-1:0];
	endfunction

endpackage

// ===== design/csc_mul.sv =====
`timescale 1ns / 1ps

module csc_mul (
	input  logic               clk,
	input  logic signed [27:0] a,
	input  logic signed [24:0] b,
	output logic signed [52:0] p
);

	logic signed [52:0] p_q;

	// registered signed product
	always_ff @(posedge clk) begin
		p_q <= 53'(a) * 53'(b);
	end

	assign p = p_q;

endmodule

// ===== design/csc_divsqrt.sv =====
`timescale 1ns / 1ps

module csc_divsqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  csc_pkg::div_cmd_t  cmd,
	output csc_pkg::div_sts_t  sts
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        sqrt_q;
	logic [csc_pkg::DIV_REM_W-1:0] rem_q;
	logic [csc_pkg::DIV_LOW_W-1:0] low_q;
	logic [csc_pkg::DIV_DEN_W-1:0] den_q;
	logic [16:0] q_q;
	logic [49:0] root_q;
	logic [49:0] bit_q;

	logic [csc_pkg::DIV_REM_W-1:0] r2;
	logic        div_ge;
	logic [49:0] trial;
	logic        sq_ge;

	// one restoring step and one square root step
	always_comb begin
		r2     = {rem_q[csc_pkg::DIV_REM_W-2:0], low_q[csc_pkg::DIV_LOW_W-1]};
		div_ge = r2 >= {2'b00, den_q};
		trial  = root_q + bit_q;
		sq_ge  = rem_q[49:0] >= trial;
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath of the shared unit
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.sqrt;
			rem_q  <= cmd.rem0;
			low_q  <= cmd.low;
			den_q  <= cmd.den;
			q_q    <= '0;
			root_q <= '0;
			bit_q  <= 50'd1 << csc_pkg::SQRT_TOP;
		end else if (busy_q) begin
			if (sqrt_q) begin
				if (sq_ge) begin
					rem_q  <= {2'b00, rem_q[49:0] - trial};
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q <= div_ge ? r2 - {2'b00, den_q} : r2;
				q_q   <= {q_q[15:0], div_ge};
				low_q <= {low_q[csc_pkg::DIV_LOW_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.res  = sqrt_q ? root_q[csc_pkg::RES_W-1:0] : {9'd0, q_q};

endmodule

// ===== design/circle_segment_collision_resolve.sv =====
`timescale 1ns / 1ps
// Circle against wall segment collision resolver.
// Input stream s_*: s_tuser is the kind (0 loads one wall into the slot given
// by wall_index, 1 is a circle query). A load gives no result and leaves the
// sequencer idle. A query walks the first wall_count walls (at most MAX_WALLS)
// PASSES times and returns one transaction on m_*: new centre, new velocity
// and the hit flag.
// All arithmetic goes through one registered multiplier and one iterative
// divide / square root unit under a sequencer. A wall with no contact takes
// the short path, one with contact and reflection the longest, and the next
// transaction can be taken once the result is in the output register. The
// square root (25 steps) and the two normal divisions (17 steps each) are
// the longest parts of the walk of a wall.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register, so a new transaction is taken while it waits. If the
// receiver stalls, the next query waits at the end of its walk until the
// output register frees. Reset clears the sequencer, the output valid and
// wall_count; the wall table is not cleared and a slot must be loaded before
// a query uses it.
module circle_segment_collision_resolve #(
	parameter int MAX_WALLS = 8,
	parameter int PASSES    = 2,
	parameter int FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// wall_index, load_start_x, load_start_y, load_end_x, load_end_y, pos_x, pos_y,
	// vel_x, vel_y, radius, energy_loss, zero padding
	input  logic [231:0] s_tdata,
	// kind
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit, zero padding
	output logic [103:0] m_tdata,
	input  logic         wall_count_we,
	input  logic [3:0]   wall_count_wdata
);

	localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int WW = $clog2(MAX_WALLS + 1);
	localparam int NW = (WW > 4) ? WW : 4;
	localparam int PW = (PASSES > 1) ? $clog2(PASSES + 1) : 1;
	localparam logic [63:0] ONE_F    = 64'd1 << FRAC_BITS;
	localparam logic [63:0] LSQ_EPS  = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
	localparam logic [63:0] DIST_EPS = (64'd1 << FRAC_BITS) / 64'd1000;

	typedef enum logic [33:0] {
		ST_IDLE   = 34'd1 << 0,
		ST_FETCH  = 34'd1 << 1,
		ST_LOAD   = 34'd1 << 2,
		ST_LSQ_A  = 34'd1 << 3,
		ST_LSQ_B  = 34'd1 << 4,
		ST_LSQ_C  = 34'd1 << 5,
		ST_DOT_A  = 34'd1 << 6,
		ST_DOT_B  = 34'd1 << 7,
		ST_TDIV   = 34'd1 << 8,
		ST_TC_I   = 34'd1 << 9,
		ST_TC_A   = 34'd1 << 10,
		ST_TC_B   = 34'd1 << 11,
		ST_DIFF   = 34'd1 << 12,
		ST_SQ_A   = 34'd1 << 13,
		ST_SQ_B   = 34'd1 << 14,
		ST_SQ_C   = 34'd1 << 15,
		ST_SQRT   = 34'd1 << 16,
		ST_CHK    = 34'd1 << 17,
		ST_NX     = 34'd1 << 18,
		ST_NY     = 34'd1 << 19,
		ST_PUSH_I = 34'd1 << 20,
		ST_PUSH_A = 34'd1 << 21,
		ST_PUSH_B = 34'd1 << 22,
		ST_VDN_A  = 34'd1 << 23,
		ST_VDN_B  = 34'd1 << 24,
		ST_RF_I   = 34'd1 << 25,
		ST_RF_A   = 34'd1 << 26,
		ST_RF_B   = 34'd1 << 27,
		ST_RF_C   = 34'd1 << 28,
		ST_RF_D   = 34'd1 << 29,
		ST_RF_E   = 34'd1 << 30,
		ST_RF_F   = 34'd1 << 31,
		ST_NEXT   = 34'd1 << 32,
		ST_OUT    = 34'd1 << 33
	} state_t;

	state_t state_q;

	// input fields
	logic                     in_kind;
	logic [2:0]               in_wall_index;
	logic [23:0]              in_lsx, in_lsy, in_lex, in_ley;
	logic signed [23:0]       in_pos_x, in_pos_y, in_vel_x, in_vel_y;
	logic [15:0]              in_radius;
	logic [16:0]              in_energy_loss;

	assign in_kind        = s_tuser[0];
	assign in_wall_index  = s_tdata[2:0];
	assign in_lsx         = s_tdata[26:3];
	assign in_lsy         = s_tdata[50:27];
	assign in_lex         = s_tdata[74:51];
	assign in_ley         = s_tdata[98:75];
	assign in_pos_x       = $signed(s_tdata[122:99]);
	assign in_pos_y       = $signed(s_tdata[146:123]);
	assign in_vel_x       = $signed(s_tdata[170:147]);
	assign in_vel_y       = $signed(s_tdata[194:171]);
	assign in_radius      = s_tdata[210:195];
	assign in_energy_loss = s_tdata[227:211];

	logic s_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// configuration
	logic [3:0] wall_count_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_count_q <= '0;
		end else if (wall_count_we) begin
			wall_count_q <= wall_count_wdata;
		end
	end

	logic [NW-1:0] n_walls;
	assign n_walls = (NW'(wall_count_q) > NW'(MAX_WALLS)) ? NW'(MAX_WALLS) : NW'(wall_count_q);

	// wall table
	logic [23:0] wsx_mem [MAX_WALLS];
	logic [23:0] wsy_mem [MAX_WALLS];
	logic [23:0] wex_mem [MAX_WALLS];
	logic [23:0] wey_mem [MAX_WALLS];
	logic [23:0] rd_sx_q, rd_sy_q, rd_ex_q, rd_ey_q;
	logic [NW-1:0] w_q;
	logic [PW-1:0] pass_q;

	always_ff @(posedge clk) begin
		if (s_acc && (in_kind == csc_pkg::KIND_LOAD) && (32'(in_wall_index) < MAX_WALLS)) begin
			wsx_mem[AW'(in_wall_index)] <= in_lsx;
			wsy_mem[AW'(in_wall_index)] <= in_lsy;
			wex_mem[AW'(in_wall_index)] <= in_lex;
			wey_mem[AW'(in_wall_index)] <= in_ley;
		end
		rd_sx_q <= wsx_mem[w_q[AW-1:0]];
		rd_sy_q <= wsy_mem[w_q[AW-1:0]];
		rd_ex_q <= wex_mem[w_q[AW-1:0]];
		rd_ey_q <= wey_mem[w_q[AW-1:0]];
	end

	// working registers
	logic signed [23:0] px_q, py_q, vx_q, vy_q;
	logic [17:0]        rad1_q;
	logic [16:0]        loss_q;
	logic               hit_q;
	logic signed [24:0] ax_q, ay_q, abx_q, aby_q, cx_q, cy_q, dx_q, dy_q;
	logic [49:0]        lsq_q;
	logic [16:0]        t_q;
	logic [25:0]        dist_q;
	logic signed [17:0] nx_q, ny_q;
	logic signed [43:0] vdn_q;
	logic signed [27:0] rx_q, ry_q;
	logic signed [52:0] acc_q;

	// shared multiplier
	logic signed [27:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [52:0] mul_p;

	csc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// shared divide / square root unit
	csc_pkg::div_cmd_t div_cmd;
	csc_pkg::div_sts_t div_sts;

	csc_divsqrt u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.sts    (div_sts)
	);

	// derived values
	logic signed [52:0] sum_ap;
	logic               dot_pos, dot_ge, contact;
	logic [17:0]        pen_w;
	logic [24:0]        dxm, dym;
	logic [42:0]        num_x, num_y;
	logic signed [63:0] refl_p;

	always_comb begin
		sum_ap  = acc_q + mul_p;
		dot_pos = !sum_ap[52] && (sum_ap != '0);
		dot_ge  = sum_ap >= $signed({3'b000, lsq_q});
		contact = (dist_q < 26'(rad1_q)) && (64'(dist_q) > DIST_EPS);
		pen_w   = rad1_q - 18'(dist_q);
		dxm     = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
		dym     = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);
		num_x   = 43'({dxm, 16'd0}) + 43'(dist_q >> 1);
		num_y   = 43'({dym, 16'd0}) + 43'(dist_q >> 1);
		refl_p  = (64'(mul_p) <<< 24) + 64'(acc_q);
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LSQ_A:  begin mul_a = 28'(abx_q); mul_b = abx_q; end
			ST_LSQ_B:  begin mul_a = 28'(aby_q); mul_b = aby_q; end
			ST_LSQ_C:  begin mul_a = 28'(26'(px_q) - 26'(ax_q)); mul_b = abx_q; end
			ST_DOT_A:  begin mul_a = 28'(26'(py_q) - 26'(ay_q)); mul_b = aby_q; end
			ST_TC_I:   begin mul_a = 28'(abx_q); mul_b = $signed({8'd0, t_q}); end
			ST_TC_A:   begin mul_a = 28'(aby_q); mul_b = $signed({8'd0, t_q}); end
			ST_SQ_A:   begin mul_a = 28'(dx_q); mul_b = dx_q; end
			ST_SQ_B:   begin mul_a = 28'(dy_q); mul_b = dy_q; end
			ST_PUSH_I: begin mul_a = 28'(nx_q); mul_b = $signed({7'd0, pen_w}); end
			ST_PUSH_A: begin mul_a = 28'(ny_q); mul_b = $signed({7'd0, pen_w}); end
			ST_PUSH_B: begin mul_a = 28'(vx_q); mul_b = 25'(nx_q); end
			ST_VDN_A:  begin mul_a = 28'(vy_q); mul_b = 25'(ny_q); end
			ST_RF_I:   begin mul_a = 28'(nx_q); mul_b = $signed({1'b0, vdn_q[23:0]}); end
			ST_RF_A:   begin mul_a = 28'(nx_q); mul_b = 25'($signed(vdn_q[43:24])); end
			ST_RF_B:   begin mul_a = 28'(ny_q); mul_b = $signed({1'b0, vdn_q[23:0]}); end
			ST_RF_C:   begin mul_a = 28'(ny_q); mul_b = 25'($signed(vdn_q[43:24])); end
			ST_RF_D:   begin mul_a = rx_q; mul_b = $signed({8'd0, loss_q}); end
			ST_RF_E:   begin mul_a = ry_q; mul_b = $signed({8'd0, loss_q}); end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// divide / square root commands
	always_comb begin
		div_cmd       = '0;
		div_cmd.steps = csc_pkg::T_STEPS;
		unique case (state_q)
			ST_DOT_B: begin
				div_cmd.start = dot_pos && !dot_ge;
				div_cmd.rem0  = 52'(sum_ap[50:0]);
				div_cmd.den   = lsq_q;
			end
			ST_SQ_C: begin
				div_cmd.start = 1'b1;
				div_cmd.sqrt  = 1'b1;
				div_cmd.steps = csc_pkg::SQRT_STEPS;
				div_cmd.rem0  = 52'(sum_ap[49:0]);
			end
			ST_CHK: begin
				div_cmd.start = contact;
				div_cmd.steps = csc_pkg::NORM_STEPS;
				div_cmd.rem0  = 52'(num_x >> 17);
				div_cmd.low   = num_x[16:0];
				div_cmd.den   = 50'(dist_q);
			end
			ST_NX: begin
				div_cmd.start = div_sts.done;
				div_cmd.steps = csc_pkg::NORM_STEPS;
				div_cmd.rem0  = 52'(num_y >> 17);
				div_cmd.low   = num_y[16:0];
				div_cmd.den   = 50'(dist_q);
			end
			default: begin
				div_cmd.start = 1'b0;
			end
		endcase
	end

	// output register
	logic         m_tvalid_q;
	logic [103:0] m_tdata_q;
	logic         out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= {7'd0, hit_q, vy_q, vx_q, py_q, px_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && (in_kind == csc_pkg::KIND_QUERY)) begin
						w_q     <= '0;
						pass_q  <= '0;
						state_q <= (n_walls == '0) ? ST_OUT : ST_FETCH;
					end
				end
				ST_FETCH:  state_q <= ST_LOAD;
				ST_LOAD:   state_q <= ST_LSQ_A;
				ST_LSQ_A:  state_q <= ST_LSQ_B;
				ST_LSQ_B:  state_q <= ST_LSQ_C;
				ST_LSQ_C: begin
					state_q <= ({14'd0, sum_ap[49:0]} >= LSQ_EPS) ? ST_DOT_A : ST_DIFF;
				end
				ST_DOT_A:  state_q <= ST_DOT_B;
				ST_DOT_B:  state_q <= (dot_pos && !dot_ge) ? ST_TDIV : ST_DIFF;
				ST_TDIV: begin
					if (div_sts.done) begin
						state_q <= ST_TC_I;
					end
				end
				ST_TC_I:   state_q <= ST_TC_A;
				ST_TC_A:   state_q <= ST_TC_B;
				ST_TC_B:   state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_SQ_A;
				ST_SQ_A:   state_q <= ST_SQ_B;
				ST_SQ_B:   state_q <= ST_SQ_C;
				ST_SQ_C:   state_q <= ST_SQRT;
				ST_SQRT: begin
					if (div_sts.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK:    state_q <= contact ? ST_NX : ST_NEXT;
				ST_NX: begin
					if (div_sts.done) begin
						state_q <= ST_NY;
					end
				end
				ST_NY: begin
					if (div_sts.done) begin
						state_q <= ST_PUSH_I;
					end
				end
				ST_PUSH_I: state_q <= ST_PUSH_A;
				ST_PUSH_A: state_q <= ST_PUSH_B;
				ST_PUSH_B: state_q <= ST_VDN_A;
				ST_VDN_A:  state_q <= ST_VDN_B;
				ST_VDN_B:  state_q <= sum_ap[52] ? ST_RF_I : ST_NEXT;
				ST_RF_I:   state_q <= ST_RF_A;
				ST_RF_A:   state_q <= ST_RF_B;
				ST_RF_B:   state_q <= ST_RF_C;
				ST_RF_C:   state_q <= ST_RF_D;
				ST_RF_D:   state_q <= ST_RF_E;
				ST_RF_E:   state_q <= ST_RF_F;
				ST_RF_F:   state_q <= ST_NEXT;
				ST_NEXT: begin
					if (w_q + NW'(1) == n_walls) begin
						w_q <= '0;
						if (pass_q + PW'(1) == PW'(PASSES)) begin
							state_q <= ST_OUT;
						end else begin
							pass_q  <= pass_q + PW'(1);
							state_q <= ST_FETCH;
						end
					end else begin
						w_q     <= w_q + NW'(1);
						state_q <= ST_FETCH;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && (in_kind == csc_pkg::KIND_QUERY)) begin
					px_q   <= in_pos_x;
					py_q   <= in_pos_y;
					vx_q   <= in_vel_x;
					vy_q   <= in_vel_y;
					rad1_q <= 18'(in_radius) + 18'(ONE_F);
					loss_q <= in_energy_loss;
					hit_q  <= 1'b0;
				end
			end
			ST_LOAD: begin
				ax_q  <= 25'($signed(rd_sx_q));
				ay_q  <= 25'($signed(rd_sy_q));
				abx_q <= 25'($signed(rd_ex_q)) - 25'($signed(rd_sx_q));
				aby_q <= 25'($signed(rd_ey_q)) - 25'($signed(rd_sy_q));
			end
			ST_LSQ_B: acc_q <= mul_p;
			ST_LSQ_C: begin
				lsq_q <= sum_ap[49:0];
				cx_q  <= ax_q;
				cy_q  <= ay_q;
			end
			ST_DOT_A: acc_q <= mul_p;
			ST_DOT_B: begin
				if (dot_pos && dot_ge) begin
					cx_q <= ax_q + abx_q;
					cy_q <= ay_q + aby_q;
				end
			end
			ST_TDIV: begin
				if (div_sts.done) begin
					t_q <= div_sts.res[16:0];
				end
			end
			ST_TC_A: cx_q <= ax_q + 25'(csc_pkg::rshr(64'(mul_p), 16));
			ST_TC_B: cy_q <= ay_q + 25'(csc_pkg::rshr(64'(mul_p), 16));
			ST_DIFF: begin
				dx_q <= 25'(26'(px_q) - 26'(cx_q));
				dy_q <= 25'(26'(py_q) - 26'(cy_q));
			end
			ST_SQ_B: acc_q <= mul_p;
			ST_SQRT: begin
				if (div_sts.done) begin
					dist_q <= div_sts.res;
				end
			end
			ST_NX: begin
				if (div_sts.done) begin
					nx_q <= dx_q[24] ? -$signed({1'b0, div_sts.res[16:0]})
						: $signed({1'b0, div_sts.res[16:0]});
				end
			end
			ST_NY: begin
				if (div_sts.done) begin
					ny_q <= dy_q[24] ? -$signed({1'b0, div_sts.res[16:0]})
						: $signed({1'b0, div_sts.res[16:0]});
				end
			end
			ST_PUSH_A: px_q <= csc_pkg::sat24(64'(px_q) + csc_pkg::rshr(64'(mul_p), 16));
			ST_PUSH_B: py_q <= csc_pkg::sat24(64'(py_q) + csc_pkg::rshr(64'(mul_p), 16));
			ST_VDN_A:  acc_q <= mul_p;
			ST_VDN_B: begin
				vdn_q <= sum_ap[43:0];
				hit_q <= 1'b1;
			end
			ST_RF_A: acc_q <= mul_p;
			ST_RF_B: rx_q <= 28'(64'(vx_q) - csc_pkg::rshr(refl_p, 31));
			ST_RF_C: acc_q <= mul_p;
			ST_RF_D: ry_q <= 28'(64'(vy_q) - csc_pkg::rshr(refl_p, 31));
			ST_RF_E: vx_q <= csc_pkg::sat24(csc_pkg::rshr(64'(mul_p), 16));
			ST_RF_F: vy_q <= csc_pkg::sat24(csc_pkg::rshr(64'(mul_p), 16));
			default: begin
			end
		endcase
	end

	// checks
	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> (state_q == ST_TDIV || state_q == ST_SQRT ||
			state_q == ST_NX || state_q == ST_NY))
		else $error("divide unit busy outside a wait state");

	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == csc_pkg::KIND_QUERY)) |=> !s_tready)
		else $error("input taken while a query is in progress");

	a_wall_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT) |-> (w_q < n_walls))
		else $error("wall index beyond wall count");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

endmodule

// ===== verif/csc_checker.sv =====
`timescale 1ns / 1ps

module csc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [231:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic         wall_count_we,
	input  logic [3:0]   wall_count_wdata,
	output int           fail_count,
	output int           pending
);
	localparam int NWALLS = 8;
	localparam int NPASS  = 2;
	localparam int FRAC   = 8;

	typedef struct {
		logic signed [23:0] px, py, vx, vy;
		logic               hit;
	} motion_t;

	motion_t resolved_q[$];
	logic signed [23:0] ws_x[NWALLS], ws_y[NWALLS], we_x[NWALLS], we_y[NWALLS];
	logic [3:0] walls_used;

	function automatic longint rnd_shift(longint v, int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic longint int_sqrt(longint x);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > x) b = b >>> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint unit_div(longint d, longint den);
		longint m, q;
		m = d < 0 ? -d : d;
		q = ((m <<< 16) + (den >>> 1)) / den;
		return d < 0 ? -q : q;
	endfunction

	// resolve one circle query against the wall table
	function automatic motion_t resolve_circle(logic [231:0] d);
		motion_t res;
		longint px, py, vx, vy, rad1, loss, ax, ay, abx, aby, cx, cy, dx, dy;
		longint lsq, dotp, rm, t, dist_v, nx, ny, pen, vdn, rx, ry;
		int nw;
		// fields: idx 2..0, sx 26..3, sy 50..27, ex 74..51, ey 98..75,
		// px 122..99, py 146..123, vx 170..147, vy 194..171, rad 210..195, loss 227..211
		px = longint'($signed(d[122:99]));
		py = longint'($signed(d[146:123]));
		vx = longint'($signed(d[170:147]));
		vy = longint'($signed(d[194:171]));
		rad1 = longint'(d[210:195]) + (64'sd1 <<< FRAC);
		loss = longint'(d[227:211]);
		nw = walls_used > NWALLS ? NWALLS : walls_used;
		res.hit = 1'b0;
		for (int p = 0; p < NPASS; p++) begin
			for (int w = 0; w < nw; w++) begin
				ax = ws_x[w]; ay = ws_y[w];
				abx = longint'(we_x[w]) - ax; aby = longint'(we_y[w]) - ay;
				cx = ax; cy = ay;
				lsq = abx * abx + aby * aby;
				if (lsq >= ((64'sd1 <<< (2 * FRAC)) / 10000)) begin
					dotp = (px - ax) * abx + (py - ay) * aby;
					if (dotp > 0 && dotp >= lsq) begin
						cx = ax + abx; cy = ay + aby;
					end else if (dotp > 0) begin
						rm = dotp; t = 0;
						for (int k = 0; k < 16; k++) begin
							rm = rm <<< 1; t = t <<< 1;
							if (rm >= lsq) begin
								rm = rm - lsq; t = t | 1;
							end
						end
						cx = ax + rnd_shift(abx * t, 16);
						cy = ay + rnd_shift(aby * t, 16);
					end
				end
				dx = px - cx; dy = py - cy;
				dist_v = int_sqrt(dx * dx + dy * dy);
				if (!(dist_v < rad1 && dist_v > ((64'sd1 <<< FRAC) / 1000))) continue;
				nx = unit_div(dx, dist_v);
				ny = unit_div(dy, dist_v);
				pen = rad1 - dist_v;
				px = clamp24(px + rnd_shift(nx * pen, 16));
				py = clamp24(py + rnd_shift(ny * pen, 16));
				vdn = vx * nx + vy * ny;
				if (vdn < 0) begin
					rx = vx - rnd_shift(2 * nx * vdn, 32);
					ry = vy - rnd_shift(2 * ny * vdn, 32);
					vx = clamp24(rnd_shift(rx * loss, 16));
					vy = clamp24(rnd_shift(ry * loss, 16));
				end
				res.hit = 1'b1;
			end
		end
		res.px = px[23:0]; res.py = py[23:0]; res.vx = vx[23:0]; res.vy = vy[23:0];
		return res;
	endfunction

	assign pending = resolved_q.size();

	// track config, loads and queries; compare each result transaction
	always @(posedge clk or negedge arst_n) begin
		motion_t exp_m;
		if (!arst_n) begin
			walls_used <= '0;
			fail_count <= 0;
		end else begin
			if (wall_count_we) walls_used <= wall_count_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == csc_pkg::KIND_LOAD) begin
					ws_x[s_tdata[2:0]] = s_tdata[26:3];
					ws_y[s_tdata[2:0]] = s_tdata[50:27];
					we_x[s_tdata[2:0]] = s_tdata[74:51];
					we_y[s_tdata[2:0]] = s_tdata[98:75];
				end else begin
					resolved_q.insert(resolved_q.size(), resolve_circle(s_tdata));
				end
			end
			if (m_tvalid && m_tready) begin
				if (resolved_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_m = resolved_q.pop_front();
					if (m_tdata[23:0] !== exp_m.px || m_tdata[47:24] !== exp_m.py
							|| m_tdata[71:48] !== exp_m.vx || m_tdata[95:72] !== exp_m.vy
							|| m_tdata[96] !== exp_m.hit) begin
						$display("%0t: mismatch expected %h %h %h %h %b actual %h %h %h %h %b",
							$time, exp_m.px, exp_m.py, exp_m.vx, exp_m.vy, exp_m.hit,
							m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
							m_tdata[95:72], m_tdata[96]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb_circle_segment_collision_resolve.sv =====
`timescale 1ns / 1ps

module tb_circle_segment_collision_resolve;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [231:0] s_tdata = '0;
	logic [0:0]   s_tuser = csc_pkg::KIND_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         wall_count_we = 1'b0;
	logic [3:0]   wall_count_wdata = '0;
	int           fail_count, pending;
	int           send_idle_pct = 0, recv_idle_pct = 0;
	bit           hold_off = 1'b0;

	circle_segment_collision_resolve u_dut (.*);
	csc_checker u_chk (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver readiness, with a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) m_tready <= 1'b0;
			else m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one transaction; returns at the accepting edge with tvalid still high
	task automatic send(logic [0:0] kind, logic [231:0] d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// drop tvalid after the last transaction of a run
	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_coord(int spread);
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return {$urandom} & 24'hFFFFFF;
			default: return 24'($signed($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	task automatic load_wall(logic [2:0] idx, logic [23:0] sx, sy, ex, ey);
		send(csc_pkg::KIND_LOAD, {133'b0, ey, ex, sy, sx, idx});
	endtask

	task automatic query(logic [23:0] px, py, vx, vy, logic [15:0] rad, logic [16:0] loss);
		send(csc_pkg::KIND_QUERY, {4'b0, loss, rad, vy, vx, py, px, 99'b0});
	endtask

	task automatic set_walls(logic [3:0] n);
		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
		wall_count_we <= 1'b1;
		wall_count_wdata <= n;
		@(negedge clk);
		wall_count_we <= 1'b0;
	endtask

	task automatic random_item();
		int spread;
		spread = $urandom_range(3) == 0 ? 8000000 : 4000;
		if ($urandom_range(5) == 0)
			load_wall(3'($urandom), rand_coord(spread), rand_coord(spread),
				rand_coord(spread), rand_coord(spread));
		else
			query(rand_coord(spread), rand_coord(spread), rand_coord(spread),
				rand_coord(spread), 16'($urandom_range(3) == 0 ? $urandom
				: $urandom_range(3000)), 17'($urandom_range(3) == 0 ? $urandom_range(131071)
				: $urandom_range(65536)));
	endtask

	initial begin
		logic [3:0] cnt;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: load every slot, then query extremes
		load_wall(0, 24'h000000, 24'h000000, 24'h000A00, 24'h000000);
		load_wall(1, 24'h000500, 24'h000500, 24'h000500, 24'h000500);
		load_wall(2, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
		load_wall(3, 24'hFFF000, 24'h001000, 24'h001000, 24'h001000);
		load_wall(4, 24'h000000, 24'h000200, 24'h000000, 24'hFFFE00);
		load_wall(5, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
		load_wall(6, 24'h000100, 24'h000000, 24'h000101, 24'h000000);
		load_wall(7, 24'h000300, 24'hFFFD00, 24'hFFFD00, 24'h000300);
		query(24'h000100, 24'h000080, 24'h000000, 24'hFFFF00, 16'h0200, 17'h10000);
		set_walls(4'd8);
		query(24'h000500, 24'h000080, 24'h000100, 24'hFFFE00, 16'h0200, 17'h08000);
		query(24'h000500, 24'h000500, 24'h000000, 24'h000000, 16'hFFFF, 17'h1FFFF);
		query(24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 16'h0000, 17'h00000);
		query(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 17'h1FFFF);
		query(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 17'h10000);
		query(24'hFFF800, 24'h000100, 24'h000400, 24'h000000, 16'h0100, 17'h0C000);
		query(24'h000C00, 24'h000000, 24'hFFFC00, 24'h000000, 16'h0300, 17'h10000);
		set_walls(4'd15);
		query(24'h000100, 24'h000100, 24'h000100, 24'h000100, 16'h0400, 17'h10000);
		// random phases over idle patterns and wall counts
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 12 : (ph == 1 ? 55 : 0);
			recv_idle_pct = ph == 0 ? 55 : (ph == 1 ? 12 : 0);
			for (int b = 0; b < 9; b++) begin
				cnt = (ph == 0 && b == 0) ? 4'd0 : (b == 8 ? 4'd8 : 4'($urandom_range(9)));
				set_walls(cnt);
				if (ph == 2 && b == 4) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (4000) @(negedge clk);
							hold_off = 1'b0;
						end
						repeat (6) random_item();
					join
				end
				for (int i = 0; i < 50; i++) random_item();
			end
		end
		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (1000) @(negedge clk);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

// ===== sim.f =====
design/csc_pkg.sv
design/csc_mul.sv
design/csc_divsqrt.sv
design/circle_segment_collision_resolve.sv
verif/csc_checker.sv
verif/tb_circle_segment_collision_resolve.sv
